[rtl/dual_gate_wing_controller_core_macros.svh]
// Assertion helpers for the gate wing controller
`ifndef DUAL_GATE_WING_CONTROLLER_CORE_MACROS_SVH
`define DUAL_GATE_WING_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication, idle during reset
`define DGWC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, idle during reset
`define DGWC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/dgwc_pkg.sv]
package dgwc_pkg;

   // wing states
   localparam logic [2:0] ST_UNKNOWN      = 3'd0;
   localparam logic [2:0] ST_CLOSED       = 3'd1;
   localparam logic [2:0] ST_OPENING      = 3'd2;
   localparam logic [2:0] ST_OPENED       = 3'd3;
   localparam logic [2:0] ST_CLOSING      = 3'd4;
   localparam logic [2:0] ST_STOP_OPENING = 3'd5;
   localparam logic [2:0] ST_STOP_CLOSING = 3'd6;

   // commands; CMD_NONE stands for a command that does nothing
   localparam logic [2:0] CMD_OPEN      = 3'd0;
   localparam logic [2:0] CMD_CLOSE     = 3'd1;
   localparam logic [2:0] CMD_USER_STOP = 3'd2;
   localparam logic [2:0] CMD_NEXT      = 3'd3;
   localparam logic [2:0] CMD_ENDSTOP   = 3'd4;
   localparam logic [2:0] CMD_NONE      = 3'd7;

   // wing select codes; the spare code acts on the left wing
   localparam logic [1:0] SEL_RIGHT = 2'd0;
   localparam logic [1:0] SEL_LEFT  = 2'd1;
   localparam logic [1:0] SEL_BOTH  = 2'd2;
   localparam logic [1:0] SEL_SPARE = 2'd3;

   localparam logic WING_RIGHT = 1'b0;
   localparam logic WING_LEFT  = 1'b1;

   typedef struct packed {
      logic [2:0]         command;
      logic [1:0]         wing_select;
      logic signed [15:0] right_pulse_count;
      logic signed [15:0] left_pulse_count;
   } req_type;

   typedef struct packed {
      logic               wing_id;
      logic [2:0]         leaf_state;
      logic [2:0]         combined_state;
      logic               motor_run;
      logic               motor_dir;
      logic signed [15:0] open_position;
      logic               open_calibrated;
      logic signed [15:0] closed_position;
      logic               closed_calibrated;
      logic               last;
   } rsp_type;

   // everything kept for one wing
   typedef struct packed {
      logic [2:0]         state;
      logic               run;
      logic               dir;
      logic signed [15:0] open_pos;
      logic               open_cal;
      logic signed [15:0] closed_pos;
      logic               closed_cal;
   } wing_rec_type;

   typedef struct packed {
      wing_rec_type rec;
      logic         emit;
   } wing_step_type;

   // result beats handed from the engine to the result queue
   typedef struct packed {
      logic [1:0] count;
      rsp_type    beat0;
      rsp_type    beat1;
   } push_type;

   // two-wing combined state
   function automatic logic [2:0] combine(logic [2:0] r, logic [2:0] l);
      logic [2:0] c;
      if (r == l) begin
         c = r;
      end else if (r == ST_OPENING || l == ST_OPENING) begin
         c = ST_OPENING;
      end else if (r == ST_CLOSING || l == ST_CLOSING) begin
         c = ST_CLOSING;
      end else begin
         c = ST_OPENED;
      end
      return c;
   endfunction

   // one command applied to one wing
   function automatic wing_step_type wing_step(logic [2:0] cmd, wing_rec_type cur,
                                               logic signed [15:0] pcnt);
      wing_step_type res;
      logic [2:0]    eff;
      res.rec  = cur;
      res.emit = 1'b0;
      eff      = cmd;
      // next state resolves to a concrete command
      if (cmd == CMD_NEXT) begin
         case (cur.state)
            ST_OPENED, ST_STOP_OPENING:             eff = CMD_CLOSE;
            ST_CLOSED, ST_STOP_CLOSING, ST_UNKNOWN: eff = CMD_OPEN;
            ST_OPENING, ST_CLOSING:                 eff = CMD_USER_STOP;
            default:                                eff = CMD_NONE;
         endcase
      end
      case (eff)
         CMD_OPEN: begin
            if (cur.state != ST_OPENING) begin
               res.rec.state = ST_OPENING;
               res.rec.run   = 1'b1;
               res.rec.dir   = 1'b0;
               res.emit      = 1'b1;
            end
         end
         CMD_CLOSE: begin
            if (cur.state != ST_CLOSING) begin
               res.rec.state = ST_CLOSING;
               res.rec.run   = 1'b1;
               res.rec.dir   = 1'b1;
               res.emit      = 1'b1;
            end
         end
         CMD_USER_STOP: begin
            if (cur.state == ST_OPENING) begin
               res.rec.state = ST_STOP_OPENING;
            end else if (cur.state == ST_CLOSING) begin
               res.rec.state = ST_STOP_CLOSING;
            end
            res.rec.run = 1'b0;
            res.emit    = 1'b1;
         end
         CMD_ENDSTOP: begin
            // endstop reached: capture position of the travel direction
            if (cur.state == ST_OPENING) begin
               res.rec.state    = ST_OPENED;
               res.rec.open_pos = pcnt;
               res.rec.open_cal = 1'b1;
            end else if (cur.state == ST_CLOSING) begin
               res.rec.state      = ST_CLOSED;
               res.rec.closed_pos = pcnt;
               res.rec.closed_cal = 1'b1;
            end
            res.rec.run = 1'b0;
            res.emit    = 1'b1;
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // status beat for one wing
   function automatic rsp_type make_beat(logic id, wing_rec_type rec, logic [2:0] comb,
                                         logic is_last);
      rsp_type b;
      b.wing_id           = id;
      b.leaf_state        = rec.state;
      b.combined_state    = comb;
      b.motor_run         = rec.run;
      b.motor_dir         = rec.dir;
      b.open_position     = rec.open_pos;
      b.open_calibrated   = rec.open_cal;
      b.closed_position   = rec.closed_pos;
      b.closed_calibrated = rec.closed_cal;
      b.last              = is_last;
      return b;
   endfunction

endpackage

[rtl/dgwc_engine.sv]
module dgwc_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dgwc_pkg::req_type req_data,
   input  logic              room,
   output dgwc_pkg::push_type push
);

   logic                   in_valid_ff;
   dgwc_pkg::req_type      in_ff;
   dgwc_pkg::wing_rec_type wing_ff [2];

   logic                   advance;
   logic                   both;
   logic                   do_right;
   logic                   do_left;
   dgwc_pkg::wing_rec_type left_start;
   dgwc_pkg::wing_step_type right_res;
   dgwc_pkg::wing_step_type left_res;
   dgwc_pkg::rsp_type      right_beat;
   dgwc_pkg::rsp_type      left_beat;

   // input register: refills in the same cycle it drains
   assign advance   = in_valid_ff && room;
   assign req_ready = !in_valid_ff || room;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   // which wings the command touches; select three acts on the left wing
   assign both     = (in_ff.wing_select == dgwc_pkg::SEL_BOTH);
   assign do_right = both || (in_ff.wing_select == dgwc_pkg::SEL_RIGHT);
   assign do_left  = both || (in_ff.wing_select == dgwc_pkg::SEL_LEFT)
                     || (in_ff.wing_select == dgwc_pkg::SEL_SPARE);

   // next state on both wings first syncs left state to right
   always_comb begin
      left_start = wing_ff[1];
      if (both && in_ff.command == dgwc_pkg::CMD_NEXT) begin
         left_start.state = wing_ff[0].state;
      end
   end

   always_comb begin
      right_res.rec  = wing_ff[0];
      right_res.emit = 1'b0;
      if (do_right) begin
         right_res = dgwc_pkg::wing_step(in_ff.command, wing_ff[0],
                                         in_ff.right_pulse_count);
      end
      left_res.rec  = left_start;
      left_res.emit = 1'b0;
      if (do_left) begin
         left_res = dgwc_pkg::wing_step(in_ff.command, left_start,
                                        in_ff.left_pulse_count);
      end
   end

   // status beats; right sees left before its update
   assign right_beat = dgwc_pkg::make_beat(dgwc_pkg::WING_RIGHT, right_res.rec,
                          dgwc_pkg::combine(right_res.rec.state, left_start.state),
                          !left_res.emit);
   assign left_beat  = dgwc_pkg::make_beat(dgwc_pkg::WING_LEFT, left_res.rec,
                          dgwc_pkg::combine(right_res.rec.state, left_res.rec.state),
                          1'b1);

   always_comb begin
      push.count = 2'd0;
      push.beat0 = right_res.emit ? right_beat : left_beat;
      push.beat1 = left_beat;
      if (advance) begin
         push.count = {1'b0, right_res.emit} + {1'b0, left_res.emit};
      end
   end

   // wing state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wing_ff[0] <= '0;
         wing_ff[1] <= '0;
      end else if (advance) begin
         wing_ff[0] <= right_res.rec;
         wing_ff[1] <= left_res.rec;
      end
   end

endmodule

[rtl/dgwc_rsp_queue.sv]
module dgwc_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  dgwc_pkg::push_type push,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output dgwc_pkg::rsp_type  rsp_data
);

   dgwc_pkg::rsp_type mem_ff [4];
   logic [1:0]        wr_ptr_ff;
   logic [1:0]        rd_ptr_ff;
   logic [2:0]        count_ff;
   logic [2:0]        count_in;
   logic              pop;

   // keep space for a two-beat item
   assign room      = (count_ff <= 3'd2);
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign count_in  = count_ff + {1'b0, push.count} - {2'b00, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + push.count;
         rd_ptr_ff <= rd_ptr_ff + {1'b0, pop};
         count_ff  <= count_in;
      end
   end

   // beat storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.beat0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + 2'd1] <= push.beat1;
      end
   end

endmodule

[rtl/dual_gate_wing_controller_core.sv]
// Flow: a taken command waits in the input register until the result queue has
//   room; it then updates the wing state and its status beats are queued for rsp.
// Throughput: one command per cycle while the result queue has room; the result
//   port carries one beat a cycle; a four-beat queue decouples the two ports.
// Reset: synchronous, active high; wings go to unknown, motors off, positions
//   and calibrated flags cleared, result queue emptied.
`include "dual_gate_wing_controller_core_macros.svh"

module dual_gate_wing_controller_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dgwc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dgwc_pkg::rsp_type rsp_data
);

   dgwc_pkg::push_type push;
   logic               room;
   logic               push_any;
   logic               push_one;
   logic               push_pair;
   logic               pair_ok;

   // command decode and wing state
   dgwc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .room      (room),
      .push      (push)
   );

   // result beat queue
   dgwc_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // checks
   assign push_any  = (push.count != 2'd0);
   assign push_one  = (push.count == 2'd1);
   assign push_pair = (push.count == 2'd2);
   assign pair_ok   = (push.beat0.wing_id == dgwc_pkg::WING_RIGHT)
                      && (push.beat1.wing_id == dgwc_pkg::WING_LEFT)
                      && !push.beat0.last && push.beat1.last;

   `DGWC_ASSERT_SAME(a_push_room, clock, reset, push_any, room, "push without room")
   `DGWC_ASSERT_SAME(a_pair_order, clock, reset, push_pair, pair_ok, "bad two-beat order")
   `DGWC_ASSERT_SAME(a_single_last, clock, reset, push_one, push.beat0.last, "single not last")
   `DGWC_ASSERT_NEXT(a_push_visible, clock, reset, push_any, rsp_valid, "beat not offered")

endmodule

[dv/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // command codes the block ignores
   localparam logic [2:0] CMD_SPARE5   = 3'd5;
   localparam logic [2:0] CMD_SPARE6   = 3'd6;

   localparam int RANDOM_PER_PHASE = 315;
   localparam int QUIET_LIMIT      = 3000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 20;

   typedef enum logic [1:0] {ROW_PREDICT, ROW_ONE, ROW_NONE} row_kind_type;

   typedef struct {
      dgwc_pkg::req_type cmd;
      row_kind_type      kind;
      dgwc_pkg::rsp_type want;
   } plan_row_type;

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   dgwc_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   dgwc_pkg::rsp_type rsp_data;

   dual_gate_wing_controller_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // gate model: index 0 right wing, 1 left wing
   logic [2:0]         wing_st[2]      = '{dgwc_pkg::ST_UNKNOWN, dgwc_pkg::ST_UNKNOWN};
   logic               wing_run[2]     = '{1'b0, 1'b0};
   logic               wing_dir[2]     = '{1'b0, 1'b0};
   logic signed [15:0] open_at[2]      = '{16'sd0, 16'sd0};
   logic signed [15:0] closed_at[2]    = '{16'sd0, 16'sd0};
   logic               open_known[2]   = '{1'b0, 1'b0};
   logic               closed_known[2] = '{1'b0, 1'b0};

   dgwc_pkg::rsp_type step_beats[$];
   dgwc_pkg::rsp_type status_due[$];
   plan_row_type      plan[$];

   int   fail_count    = 0;
   int   send_idle_pct = 0;
   int   stall_pct     = 0;
   logic long_hold     = 1'b0;
   int   quiet         = 0;
   event hold_go;

   function automatic logic [2:0] gate_state();
      if (wing_st[0] == wing_st[1]) return wing_st[0];
      if (wing_st[0] == dgwc_pkg::ST_OPENING || wing_st[1] == dgwc_pkg::ST_OPENING)
         return dgwc_pkg::ST_OPENING;
      if (wing_st[0] == dgwc_pkg::ST_CLOSING || wing_st[1] == dgwc_pkg::ST_CLOSING)
         return dgwc_pkg::ST_CLOSING;
      return dgwc_pkg::ST_OPENED;
   endfunction

   function automatic void note_status(int w);
      dgwc_pkg::rsp_type b;
      b.wing_id           = (w == 0) ? dgwc_pkg::WING_RIGHT : dgwc_pkg::WING_LEFT;
      b.leaf_state        = wing_st[w];
      b.combined_state    = gate_state();
      b.motor_run         = wing_run[w];
      b.motor_dir         = wing_dir[w];
      b.open_position     = open_at[w];
      b.open_calibrated   = open_known[w];
      b.closed_position   = closed_at[w];
      b.closed_calibrated = closed_known[w];
      b.last              = 1'b0;
      step_beats.push_back(b);
   endfunction

   // one command on one wing; next state first turns into a concrete command
   function automatic void drive_wing(logic [2:0] cmd, int w, logic signed [15:0] pcnt);
      logic [2:0] eff;
      eff = cmd;
      if (cmd == dgwc_pkg::CMD_NEXT) begin
         case (wing_st[w])
            dgwc_pkg::ST_OPENED, dgwc_pkg::ST_STOP_OPENING:
               eff = dgwc_pkg::CMD_CLOSE;
            dgwc_pkg::ST_CLOSED, dgwc_pkg::ST_STOP_CLOSING, dgwc_pkg::ST_UNKNOWN:
               eff = dgwc_pkg::CMD_OPEN;
            default:
               eff = dgwc_pkg::CMD_USER_STOP;
         endcase
      end
      case (eff)
         dgwc_pkg::CMD_OPEN: begin
            if (wing_st[w] != dgwc_pkg::ST_OPENING) begin
               wing_st[w]  = dgwc_pkg::ST_OPENING;
               wing_run[w] = 1'b1;
               wing_dir[w] = 1'b0;
               note_status(w);
            end
         end
         dgwc_pkg::CMD_CLOSE: begin
            if (wing_st[w] != dgwc_pkg::ST_CLOSING) begin
               wing_st[w]  = dgwc_pkg::ST_CLOSING;
               wing_run[w] = 1'b1;
               wing_dir[w] = 1'b1;
               note_status(w);
            end
         end
         dgwc_pkg::CMD_USER_STOP: begin
            if (wing_st[w] == dgwc_pkg::ST_OPENING) wing_st[w] = dgwc_pkg::ST_STOP_OPENING;
            else if (wing_st[w] == dgwc_pkg::ST_CLOSING) wing_st[w] = dgwc_pkg::ST_STOP_CLOSING;
            wing_run[w] = 1'b0;
            note_status(w);
         end
         dgwc_pkg::CMD_ENDSTOP: begin
            // endstop captures the count for the direction of travel
            if (wing_st[w] == dgwc_pkg::ST_OPENING) begin
               wing_st[w]    = dgwc_pkg::ST_OPENED;
               open_at[w]    = pcnt;
               open_known[w] = 1'b1;
            end else if (wing_st[w] == dgwc_pkg::ST_CLOSING) begin
               wing_st[w]      = dgwc_pkg::ST_CLOSED;
               closed_at[w]    = pcnt;
               closed_known[w] = 1'b1;
            end
            wing_run[w] = 1'b0;
            note_status(w);
         end
         default: begin
         end
      endcase
   endfunction

   // status beats caused by one command, right wing first
   function automatic void predict_command(dgwc_pkg::req_type r);
      step_beats.delete();
      if (r.command > dgwc_pkg::CMD_ENDSTOP) return;
      if (r.wing_select == dgwc_pkg::SEL_BOTH) begin
         if (r.command == dgwc_pkg::CMD_NEXT) wing_st[1] = wing_st[0];
         drive_wing(r.command, 0, r.right_pulse_count);
         drive_wing(r.command, 1, r.left_pulse_count);
      end else if (r.wing_select == dgwc_pkg::SEL_RIGHT) begin
         drive_wing(r.command, 0, r.right_pulse_count);
      end else begin
         drive_wing(r.command, 1, r.left_pulse_count);
      end
      if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
   endfunction

   function automatic dgwc_pkg::req_type cmd_beat(logic [2:0] c, logic [1:0] s,
                                                  logic signed [15:0] rp,
                                                  logic signed [15:0] lp);
      dgwc_pkg::req_type r;
      r.command           = c;
      r.wing_select       = s;
      r.right_pulse_count = rp;
      r.left_pulse_count  = lp;
      return r;
   endfunction

   // status of a lone result, so last is set
   function automatic dgwc_pkg::rsp_type wing_status(logic id, logic [2:0] s, logic [2:0] c,
                                                     logic run, logic dir,
                                                     logic signed [15:0] opos, logic ocal,
                                                     logic signed [15:0] cpos, logic ccal);
      dgwc_pkg::rsp_type b;
      b.wing_id           = id;
      b.leaf_state        = s;
      b.combined_state    = c;
      b.motor_run         = run;
      b.motor_dir         = dir;
      b.open_position     = opos;
      b.open_calibrated   = ocal;
      b.closed_position   = cpos;
      b.closed_calibrated = ccal;
      b.last              = 1'b1;
      return b;
   endfunction

   function automatic void add_row(dgwc_pkg::req_type c, row_kind_type k,
                                   dgwc_pkg::rsp_type w);
      plan_row_type row;
      row.cmd  = c;
      row.kind = k;
      row.want = w;
      plan.push_back(row);
   endfunction

   function automatic void build_plan();
      // fresh from reset: stops on idle wings still report
      add_row(cmd_beat(dgwc_pkg::CMD_USER_STOP, dgwc_pkg::SEL_RIGHT, 16'sd0, 16'sd0), ROW_ONE,
              wing_status(dgwc_pkg::WING_RIGHT, dgwc_pkg::ST_UNKNOWN, dgwc_pkg::ST_UNKNOWN,
                          1'b0, 1'b0, 16'sd0, 1'b0, 16'sd0, 1'b0));
      add_row(cmd_beat(dgwc_pkg::CMD_ENDSTOP, dgwc_pkg::SEL_LEFT, 16'sd5, 16'sd9), ROW_ONE,
              wing_status(dgwc_pkg::WING_LEFT, dgwc_pkg::ST_UNKNOWN, dgwc_pkg::ST_UNKNOWN,
                          1'b0, 1'b0, 16'sd0, 1'b0, 16'sd0, 1'b0));
      add_row(cmd_beat(dgwc_pkg::CMD_OPEN, dgwc_pkg::SEL_RIGHT, 16'sd0, 16'sd0), ROW_ONE,
              wing_status(dgwc_pkg::WING_RIGHT, dgwc_pkg::ST_OPENING, dgwc_pkg::ST_OPENING,
                          1'b1, 1'b0, 16'sd0, 1'b0, 16'sd0, 1'b0));
      // repeated open while opening is silent
      add_row(cmd_beat(dgwc_pkg::CMD_OPEN, dgwc_pkg::SEL_RIGHT, 16'sd0, 16'sd0), ROW_NONE, '0);
      add_row(cmd_beat(dgwc_pkg::CMD_ENDSTOP, dgwc_pkg::SEL_RIGHT, 16'sh7fff, 16'sd0), ROW_ONE,
              wing_status(dgwc_pkg::WING_RIGHT, dgwc_pkg::ST_OPENED, dgwc_pkg::ST_OPENED,
                          1'b0, 1'b0, 16'sh7fff, 1'b1, 16'sd0, 1'b0));
      add_row(cmd_beat(dgwc_pkg::CMD_CLOSE, dgwc_pkg::SEL_LEFT, 16'sd0, 16'sd0), ROW_ONE,
              wing_status(dgwc_pkg::WING_LEFT, dgwc_pkg::ST_CLOSING, dgwc_pkg::ST_CLOSING,
                          1'b1, 1'b1, 16'sd0, 1'b0, 16'sd0, 1'b0));
      add_row(cmd_beat(dgwc_pkg::CMD_CLOSE, dgwc_pkg::SEL_LEFT, 16'sd0, 16'sd0), ROW_NONE, '0);
      add_row(cmd_beat(dgwc_pkg::CMD_ENDSTOP, dgwc_pkg::SEL_LEFT, 16'sd0, 16'sh8000), ROW_ONE,
              wing_status(dgwc_pkg::WING_LEFT, dgwc_pkg::ST_CLOSED, dgwc_pkg::ST_OPENED,
                          1'b0, 1'b1, 16'sd0, 1'b0, 16'sh8000, 1'b1));
      // unused command codes
      add_row(cmd_beat(CMD_SPARE5, dgwc_pkg::SEL_BOTH, -16'sd1, -16'sd1), ROW_NONE, '0);
      add_row(cmd_beat(CMD_SPARE6, dgwc_pkg::SEL_RIGHT, 16'sd1, 16'sd1), ROW_NONE, '0);
      add_row(cmd_beat(dgwc_pkg::CMD_NONE, dgwc_pkg::SEL_SPARE, 16'sh7fff, 16'sh8000),
              ROW_NONE, '0);
      // next state on both copies right into left first
      add_row(cmd_beat(dgwc_pkg::CMD_NEXT, dgwc_pkg::SEL_BOTH, 16'sd0, 16'sd0),
              ROW_PREDICT, '0);
      add_row(cmd_beat(dgwc_pkg::CMD_USER_STOP, dgwc_pkg::SEL_BOTH, 16'sd0, 16'sd0),
              ROW_PREDICT, '0);
      add_row(cmd_beat(dgwc_pkg::CMD_NEXT, dgwc_pkg::SEL_RIGHT, 16'sd0, 16'sd0),
              ROW_PREDICT, '0);
      add_row(cmd_beat(dgwc_pkg::CMD_NEXT, dgwc_pkg::SEL_LEFT, 16'sd0, 16'sd0),
              ROW_PREDICT, '0);
      add_row(cmd_beat(dgwc_pkg::CMD_NEXT, dgwc_pkg::SEL_RIGHT, 16'sd0, 16'sd0),
              ROW_PREDICT, '0);
      // select code three acts on the left wing
      add_row(cmd_beat(dgwc_pkg::CMD_OPEN, dgwc_pkg::SEL_SPARE, 16'sd3, 16'sd4),
              ROW_PREDICT, '0);
      add_row(cmd_beat(dgwc_pkg::CMD_ENDSTOP, dgwc_pkg::SEL_SPARE, 16'sh8000, 16'sh7fff),
              ROW_PREDICT, '0);
      add_row(cmd_beat(dgwc_pkg::CMD_CLOSE, dgwc_pkg::SEL_BOTH, 16'sd0, 16'sd0),
              ROW_PREDICT, '0);
      add_row(cmd_beat(dgwc_pkg::CMD_ENDSTOP, dgwc_pkg::SEL_BOTH, 16'sh8000, 16'sh7fff),
              ROW_PREDICT, '0);
      add_row(cmd_beat(dgwc_pkg::CMD_OPEN, dgwc_pkg::SEL_BOTH, 16'sd0, 16'sd0),
              ROW_PREDICT, '0);
      add_row(cmd_beat(dgwc_pkg::CMD_ENDSTOP, dgwc_pkg::SEL_BOTH, -16'sd1, 16'sd1),
              ROW_PREDICT, '0);
      add_row(cmd_beat(dgwc_pkg::CMD_NEXT, dgwc_pkg::SEL_BOTH, 16'sd0, 16'sd0),
              ROW_PREDICT, '0);
      add_row(cmd_beat(dgwc_pkg::CMD_NEXT, dgwc_pkg::SEL_BOTH, 16'sd0, 16'sd0),
              ROW_PREDICT, '0);
      add_row(cmd_beat(dgwc_pkg::CMD_USER_STOP, dgwc_pkg::SEL_SPARE, 16'sd0, 16'sd0),
              ROW_PREDICT, '0);
   endfunction

   function automatic logic signed [15:0] pick_count();
      case ($urandom_range(19))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2:       return 16'sd0;
         3:       return -16'sd1;
         default: return 16'($urandom);
      endcase
   endfunction

   // mostly commands that make sense for the wing's travel, some noise
   function automatic dgwc_pkg::req_type pick_command();
      dgwc_pkg::req_type r;
      logic [2:0]        s;
      r.wing_select       = 2'($urandom_range(3));
      r.right_pulse_count = pick_count();
      r.left_pulse_count  = pick_count();
      s = (r.wing_select == dgwc_pkg::SEL_RIGHT || r.wing_select == dgwc_pkg::SEL_BOTH)
          ? wing_st[0] : wing_st[1];
      if ($urandom_range(99) < 20) begin
         r.command = 3'($urandom_range(7));
      end else if (s == dgwc_pkg::ST_OPENING || s == dgwc_pkg::ST_CLOSING) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4: r.command = dgwc_pkg::CMD_ENDSTOP;
            5, 6:          r.command = dgwc_pkg::CMD_USER_STOP;
            7, 8:          r.command = dgwc_pkg::CMD_NEXT;
            default:       r.command = (s == dgwc_pkg::ST_OPENING) ? dgwc_pkg::CMD_OPEN
                                                                   : dgwc_pkg::CMD_CLOSE;
         endcase
      end else begin
         case ($urandom_range(9))
            0, 1, 2: r.command = dgwc_pkg::CMD_OPEN;
            3, 4, 5: r.command = dgwc_pkg::CMD_CLOSE;
            6, 7:    r.command = dgwc_pkg::CMD_NEXT;
            8:       r.command = dgwc_pkg::CMD_USER_STOP;
            default: r.command = dgwc_pkg::CMD_ENDSTOP;
         endcase
      end
      return r;
   endfunction

   // offer one command beat, wait for it to be taken, then book its results
   task automatic send_beat(dgwc_pkg::req_type r, row_kind_type kind,
                            dgwc_pkg::rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_command(r);
      if (kind == ROW_PREDICT) begin
         foreach (step_beats[i]) status_due.push_back(step_beats[i]);
      end else if (kind == ROW_ONE) begin
         status_due.push_back(want);
      end
   endtask

   task automatic drain_status();
      req_valid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
   endtask

   function automatic void flag_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   function automatic void compare_status(dgwc_pkg::rsp_type got, dgwc_pkg::rsp_type want);
      flag_field("wing_id", 32'(want.wing_id), 32'(got.wing_id));
      flag_field("leaf_state", 32'(want.leaf_state), 32'(got.leaf_state));
      flag_field("combined_state", 32'(want.combined_state), 32'(got.combined_state));
      flag_field("motor_run", 32'(want.motor_run), 32'(got.motor_run));
      flag_field("motor_dir", 32'(want.motor_dir), 32'(got.motor_dir));
      flag_field("open_position", 32'(want.open_position), 32'(got.open_position));
      flag_field("open_calibrated", 32'(want.open_calibrated), 32'(got.open_calibrated));
      flag_field("closed_position", 32'(want.closed_position), 32'(got.closed_position));
      flag_field("closed_calibrated", 32'(want.closed_calibrated),
                 32'(got.closed_calibrated));
      flag_field("last", 32'(want.last), 32'(got.last));
   endfunction

   // status beat checker
   always @(posedge clock) begin
      dgwc_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (status_due.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected status beat, expected none, got %h", $time, rsp_data);
         end else begin
            want = status_due.pop_front();
            compare_status(rsp_data, want);
         end
      end
   end

   // receiver: random stalls, plus the long hold-off
   always @(posedge clock) begin
      rsp_ready <= !long_hold && ($urandom_range(99) >= stall_pct);
   end

   initial begin
      forever begin
         @(hold_go);
         long_hold <= 1'b1;
         repeat (LONG_HOLD_CYCLES) @(posedge clock);
         long_hold <= 1'b0;
      end
   end

   // watchdog on cycles with no beat moving on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet <= 0;
         end else if (quiet >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end else begin
            quiet <= quiet + 1;
         end
      end
   end

   initial begin
      int send_idle[4];
      int stall[4];
      send_idle = '{0, 80, 0, 34};
      stall     = '{0, 0, 80, 34};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows, no idling
      build_plan();
      foreach (plan[i]) send_beat(plan[i].cmd, plan[i].kind, plan[i].want);
      drain_status();

      // back-pressure: hold the result side while commands keep coming
      -> hold_go;
      for (int i = 0; i < 16; i++) send_beat(pick_command(), ROW_PREDICT, '0);
      drain_status();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = send_idle[phase];
         stall_pct    <= stall[phase];
         for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            send_beat(pick_command(), ROW_PREDICT, '0);
         end
         drain_status();
      end

      stall_pct <= 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && status_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[dual_gate_wing_controller_core.f]
+incdir+rtl
rtl/dgwc_pkg.sv
rtl/dgwc_engine.sv
rtl/dgwc_rsp_queue.sv
rtl/dual_gate_wing_controller_core.sv
dv/tb.sv
